### hw/rtl/bls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bls_pkg;

  localparam int DEPTH_DEF = 8;
  localparam int WORD_W    = 32;

  typedef enum logic [2:0] {
    MODE_PUSH    = 3'd0,
    MODE_POP     = 3'd1,
    MODE_SEARCH  = 3'd2,
    MODE_DISPLAY = 3'd3,
    MODE_UPDATE  = 3'd4,
    MODE_PEEK    = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_FULL     = 3'd1,
    STAT_EMPTY    = 3'd2,
    STAT_BADPOS   = 3'd3,
    STAT_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

  // command broadcast to every cell
  typedef struct packed {
    logic              push;   // shift towards the bottom, value enters cell 0
    logic              pop;    // shift towards the top
    logic              load;   // capture entries into the scan chain
    logic              step;   // advance the scan chain by one cell
    logic [WORD_W-1:0] value;  // push word, update word, search key
  } cmd_t;

  // one stage of the scan chain
  typedef struct packed {
    logic              vld;
    logic              hit;
    logic [WORD_W-1:0] word;
  } scan_t;

endpackage

`default_nettype wire

### hw/rtl/bls_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module bls_cell (
  input  wire logic                          clk,
  input  wire bls_pkg::cmd_t                 cmd,
  input  wire logic [bls_pkg::WORD_W-1:0]    above,
  input  wire logic [bls_pkg::WORD_W-1:0]    below,
  input  wire bls_pkg::scan_t                scan_in,
  input  wire logic                          in_range,
  input  wire logic                          upd_en,
  output bls_pkg::scan_t                     scan_out,
  output logic [bls_pkg::WORD_W-1:0]         word
);

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      word <= above;
    end else if (cmd.pop) begin
      word <= below;
    end else if (upd_en) begin
      word <= cmd.value;
    end
  end

  // scan stage: loaded from the entry, then passed on one cell per step
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      scan_out.vld  <= in_range;
      scan_out.hit  <= in_range && (word == cmd.value);
      scan_out.word <= word;
    end else if (cmd.step) begin
      scan_out <= scan_in;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/bounded_lifo_stack_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// Bounded LIFO stack of DEPTH signed 32-bit words.
// Request channel s_*: s_tuser carries the mode (push, pop, search, display,
// update, peek), s_tdata the value and the update position. Result channel
// m_*: m_tuser carries the status, m_tdata the word, slot index and fill
// count, m_tlast marks the final result of a request.
// Push, pop, update and peek give one result in the cycle after the request and
// run at one request per cycle while m_tready stays high; the next request
// is taken while a result still sits in the output register.
// Search and display load the scan chain of the cells and shift it one cell
// per cycle unless a result waits on the receiver, the bottom entry leaving first.
// A display holds the input for the load plus one step per cell; a search
// stops once its topmost match has left the chain, or with a single not-found
// result when nothing matches. Receiver stalls add to both.
// Unused mode codes are taken and dropped without a result.
// Reset (rst, synchronous) empties the stack and drops any pending result;
// entry words are not cleared, as only held entries are ever read.
// While m_tready is low the result holds in m_tdata and the walk waits at
// its next result.
module bounded_lifo_stack_engine #(
  parameter int DEPTH = bls_pkg::DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // value [31:0], position [35:32], zero pad
  input  wire logic [2:0]  s_tuser,   // mode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // data [31:0], index [34:32], count [38:35], pad
  output logic [2:0]       m_tuser,   // status
  output logic             m_tlast
);

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W  = CNT_W + 6;
  localparam logic [DEPTH-1:0] TOP_BIT = DEPTH'(1) << (DEPTH - 1);

  // request fields
  logic [bls_pkg::WORD_W-1:0] in_value;
  logic [3:0]                 in_pos;
  bls_pkg::mode_t             in_mode;

  assign in_value = s_tdata[31:0];
  assign in_pos   = s_tdata[35:32];
  assign in_mode  = bls_pkg::mode_t'(s_tuser);

  // control state
  bls_pkg::state_t  state, state_next;
  logic [CNT_W-1:0] fill, fill_next;
  logic [SLOT_W-1:0] slot, slot_next;
  logic             walk_search, walk_search_next;

  // output register
  bls_pkg::status_t           out_status, res_status;
  logic [bls_pkg::WORD_W-1:0] out_data, res_data;
  logic [2:0]                 out_index, res_index;
  logic [3:0]                 out_count, res_count;
  logic                       out_last, res_last;
  logic                       out_load;
  logic                       out_free;

  // cell chain
  bls_pkg::cmd_t              cmd;
  logic                       upd_go;
  logic [bls_pkg::WORD_W-1:0] words [DEPTH];
  bls_pkg::scan_t             scan  [DEPTH];
  logic [DEPTH-1:0]           vld_vec, hit_vec, upd_en, in_range;

  logic acc;
  logic vld_top, hit_top, any_hit, rest_vld, rest_hit;
  logic emit_want;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic [bls_pkg::WORD_W-1:0] above_w, below_w;
      bls_pkg::scan_t             scan_prev;

      // cell 0 is the top of the stack, cell fill-1 the bottom
      if (g == 0) begin : g_first
        assign above_w   = cmd.value;
        assign scan_prev = '0;
      end else begin : g_mid
        assign above_w   = words[g-1];
        assign scan_prev = scan[g-1];
      end

      if (g == DEPTH - 1) begin : g_last
        assign below_w = words[g];
      end else begin : g_inner
        assign below_w = words[g+1];
      end

      assign in_range[g] = (CNT_W'(g) < fill);
      // slot pos lives in cell fill-1-pos; slots at or above fill are not written
      assign upd_en[g]   = upd_go &&
                           ((SUM_W'(g) + SUM_W'(in_pos) + SUM_W'(1)) == SUM_W'(fill));
      assign vld_vec[g]  = scan[g].vld;
      assign hit_vec[g]  = scan[g].hit;

      bls_cell u_cell (
        .clk      (clk),
        .cmd      (cmd),
        .above    (above_w),
        .below    (below_w),
        .scan_in  (scan_prev),
        .in_range (in_range[g]),
        .upd_en   (upd_en[g]),
        .scan_out (scan[g]),
        .word     (words[g])
      );
    end
  endgenerate

  // scan chain exits at the deepest cell; the bottom entry arrives first
  assign vld_top  = scan[DEPTH-1].vld;
  assign hit_top  = scan[DEPTH-1].hit;
  assign any_hit  = |hit_vec;
  assign rest_vld = |(vld_vec & ~TOP_BIT);
  assign rest_hit = |(hit_vec & ~TOP_BIT);

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == bls_pkg::ST_IDLE) && out_free;
  assign acc      = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= bls_pkg::ST_IDLE;
      fill        <= '0;
      slot        <= '0;
      walk_search <= 1'b0;
    end else begin
      state       <= state_next;
      fill        <= fill_next;
      slot        <= slot_next;
      walk_search <= walk_search_next;
    end
  end

  always_comb begin
    state_next       = state;
    fill_next        = fill;
    slot_next        = slot;
    walk_search_next = walk_search;
    cmd              = '0;
    cmd.value        = in_value;
    upd_go           = 1'b0;
    out_load         = 1'b0;
    res_status       = bls_pkg::STAT_OK;
    res_data         = '0;
    res_index        = '0;
    res_last         = 1'b1;
    emit_want        = 1'b0;

    case (state)
      bls_pkg::ST_IDLE: begin
        if (acc) begin
          case (in_mode)
            bls_pkg::MODE_PUSH: begin
              out_load = 1'b1;
              if (fill == CNT_W'(DEPTH)) begin
                res_status = bls_pkg::STAT_FULL;
              end else begin
                cmd.push  = 1'b1;
                fill_next = fill + CNT_W'(1);
              end
            end
            bls_pkg::MODE_POP: begin
              out_load = 1'b1;
              if (fill == '0) begin
                res_status = bls_pkg::STAT_EMPTY;
              end else begin
                cmd.pop   = 1'b1;
                fill_next = fill - CNT_W'(1);
                res_data  = words[0];
              end
            end
            bls_pkg::MODE_SEARCH: begin
              if (fill == '0) begin
                out_load   = 1'b1;
                res_status = bls_pkg::STAT_NOTFOUND;
              end else begin
                cmd.load         = 1'b1;
                slot_next        = '0;
                walk_search_next = 1'b1;
                state_next       = bls_pkg::ST_WALK;
              end
            end
            bls_pkg::MODE_DISPLAY: begin
              if (fill == '0) begin
                out_load   = 1'b1;
                res_status = bls_pkg::STAT_EMPTY;
              end else begin
                cmd.load         = 1'b1;
                slot_next        = '0;
                walk_search_next = 1'b0;
                state_next       = bls_pkg::ST_WALK;
              end
            end
            bls_pkg::MODE_UPDATE: begin
              out_load = 1'b1;
              if (SUM_W'(in_pos) >= SUM_W'(DEPTH)) begin
                res_status = bls_pkg::STAT_BADPOS;
              end else begin
                upd_go = 1'b1;
              end
            end
            bls_pkg::MODE_PEEK: begin
              out_load = 1'b1;
              if (fill == '0) begin
                res_status = bls_pkg::STAT_EMPTY;
              end else begin
                res_data = words[0];
              end
            end
            default: begin
              // unused codes: dropped
            end
          endcase
        end
      end

      bls_pkg::ST_WALK: begin
        emit_want = walk_search ? (hit_top || !any_hit) : vld_top;
        if (!emit_want || out_free) begin
          cmd.step = 1'b1;
          if (vld_top) begin
            slot_next = slot + SLOT_W'(1);
          end
        end
        if (emit_want && out_free) begin
          out_load = 1'b1;
          if (walk_search) begin
            if (hit_top) begin
              res_index = 3'(slot);
              res_last  = !rest_hit;
            end else begin
              res_status = bls_pkg::STAT_NOTFOUND;
            end
          end else begin
            res_data  = scan[DEPTH-1].word;
            res_index = 3'(slot);
            res_last  = !rest_vld;
          end
          if (res_last) begin
            state_next = bls_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_next = bls_pkg::ST_IDLE;
      end
    endcase

    res_count = 4'(fill_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= res_status;
      out_data   <= res_data;
      out_index  <= res_index;
      out_count  <= res_count;
      out_last   <= res_last;
    end
  end

  assign m_tuser = out_status;
  assign m_tdata = {1'b0, out_count, out_index, out_data};
  assign m_tlast = out_last;

  // fill count never passes the depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(DEPTH))
    else $error("fill count beyond depth");

  // a walk only runs over a non-empty stack
  a_walk_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == bls_pkg::ST_WALK) |-> (fill != '0))
    else $error("walk on empty stack");

  // the stack does not change under a walk
  a_walk_fill_stable: assert property (@(posedge clk) disable iff (rst)
    (state == bls_pkg::ST_WALK) |=> $stable(fill))
    else $error("fill changed during walk");

  // a result is never loaded over one the receiver has not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !out_load)
    else $error("pending result overwritten");

endmodule

`default_nettype wire

### sim/bounded_lifo_stack_engine_test.sv
`timescale 1ns / 1ps

// one result as it leaves the m_* channel
typedef struct packed {
  logic [2:0]  status;
  logic [31:0] data;
  logic [2:0]  index;
  logic [3:0]  count;
  logic        last;
} stack_result_t;

// Mirror of the stack: works out the results each accepted request causes
// and holds them until the block delivers them.
class stack_scoreboard;
  logic [31:0]   slot_word [bls_pkg::DEPTH_DEF];
  int unsigned   held;
  stack_result_t due_results [$];
  int unsigned   errors;

  function new();
    held   = 0;
    errors = 0;
    foreach (slot_word[i]) slot_word[i] = '0;
  endfunction

  function int due_count();
    return due_results.size();
  endfunction

  // fill count is taken after the request has changed the stack
  function void add_due(bls_pkg::status_t st, logic [31:0] word, int unsigned slot,
                        logic fin);
    stack_result_t r;
    r.status = st;
    r.data   = word;
    r.index  = slot[2:0];
    r.count  = held[3:0];
    r.last   = fin;
    due_results.push_back(r);
  endfunction

  function void note_request(logic [2:0] mode, logic [31:0] value, logic [3:0] pos);
    int unsigned   hits;
    stack_result_t tail;
    hits = 0;
    case (mode)
      bls_pkg::MODE_PUSH: begin
        if (held >= bls_pkg::DEPTH_DEF) begin
          add_due(bls_pkg::STAT_FULL, '0, 0, 1'b1);
        end else begin
          slot_word[held] = value;
          held++;
          add_due(bls_pkg::STAT_OK, '0, 0, 1'b1);
        end
      end
      bls_pkg::MODE_POP: begin
        if (held == 0) begin
          add_due(bls_pkg::STAT_EMPTY, '0, 0, 1'b1);
        end else begin
          held--;
          add_due(bls_pkg::STAT_OK, slot_word[held], 0, 1'b1);
        end
      end
      bls_pkg::MODE_SEARCH: begin
        for (int unsigned i = 0; i < held; i++) begin
          if (slot_word[i] == value) begin
            add_due(bls_pkg::STAT_OK, '0, i, 1'b0);
            hits++;
          end
        end
        if (hits == 0) begin
          add_due(bls_pkg::STAT_NOTFOUND, '0, 0, 1'b1);
        end else begin
          tail      = due_results.pop_back();
          tail.last = 1'b1;
          due_results.push_back(tail);
        end
      end
      bls_pkg::MODE_DISPLAY: begin
        if (held == 0) begin
          add_due(bls_pkg::STAT_EMPTY, '0, 0, 1'b1);
        end else begin
          for (int unsigned i = 0; i < held; i++)
            add_due(bls_pkg::STAT_OK, slot_word[i], i, i + 1 == held);
        end
      end
      bls_pkg::MODE_UPDATE: begin
        if (pos >= bls_pkg::DEPTH_DEF) begin
          add_due(bls_pkg::STAT_BADPOS, '0, 0, 1'b1);
        end else begin
          // may land above the fill count; a later push overwrites it
          slot_word[pos] = value;
          add_due(bls_pkg::STAT_OK, '0, 0, 1'b1);
        end
      end
      bls_pkg::MODE_PEEK: begin
        if (held == 0) add_due(bls_pkg::STAT_EMPTY, '0, 0, 1'b1);
        else add_due(bls_pkg::STAT_OK, slot_word[held - 1], 0, 1'b1);
      end
      default: ;  // spare codes: dropped, nothing comes back
    endcase
  endfunction

  task report(string what);
    errors++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task check_result(logic [2:0] status, logic [31:0] data, logic [2:0] index,
                    logic [3:0] count, logic last);
    stack_result_t want;
    if (due_results.size() == 0) begin
      report($sformatf("result with no request outstanding, status %0d data %h",
                       status, data));
    end else begin
      want = due_results.pop_front();
      if (status !== want.status)
        report($sformatf("status %0d, expected %0d", status, want.status));
      if (data !== want.data)
        report($sformatf("data %h, expected %h", data, want.data));
      if (index !== want.index)
        report($sformatf("index %0d, expected %0d", index, want.index));
      if (count !== want.count)
        report($sformatf("count %0d, expected %0d", count, want.count));
      if (last !== want.last)
        report($sformatf("last %b, expected %b", last, want.last));
    end
  endtask
endclass

module bounded_lifo_stack_engine_test;

  // spare mode codes, which the block must swallow without a result
  localparam logic [2:0] MODE_SPARE_A = 3'd6;
  localparam logic [2:0] MODE_SPARE_B = 3'd7;

  localparam int RANDOM_REQUESTS = 400;
  localparam int LONG_HOLD       = 80;    // receiver hold-off, in cycles
  localparam int STALL_LIMIT     = 2000;  // cycles without any handshake
  localparam int SETTLE_CYCLES   = 2 * bls_pkg::DEPTH_DEF + 4;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata  = '0;   // value [31:0], position [35:32], zero pad
  logic [2:0]  s_tuser  = '0;   // mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;         // data [31:0], index [34:32], count [38:35], pad
  logic [2:0]  m_tuser;         // status
  logic        m_tlast;

  // flipped by the sender to ask the receiver for one long hold-off
  logic hold_flip = 1'b0;

  stack_scoreboard sb = new();
  int unsigned     quiet_cycles = 0;

  bounded_lifo_stack_engine uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---- request and result monitors ----
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      sb.note_request(s_tuser, s_tdata[31:0], s_tdata[35:32]);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tuser, m_tdata[31:0], m_tdata[34:32], m_tdata[38:35], m_tlast);
  end

  // ---- watchdog: too long without a handshake on either side ----
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL bounded_lifo_stack_engine");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---- receiver: changing stall pattern, plus one long hold-off on demand ----
  initial begin : receiver
    logic        seen_flip;
    int unsigned pattern;
    int unsigned span;
    int unsigned hold_left;
    int unsigned tick;
    seen_flip = 1'b0;
    pattern   = 0;
    span      = 0;
    hold_left = 0;
    tick      = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (span == 0) begin
        pattern = $urandom_range(0, 2);
        span    = $urandom_range(20, 80);
      end else begin
        span--;
      end
      if (hold_flip != seen_flip) begin
        seen_flip = hold_flip;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (pattern)
          0:       m_tready <= 1'b1;                        // no stalls
          1:       m_tready <= 1'($urandom_range(0, 1));    // coin toss
          default: m_tready <= (tick % 5) < 2;              // mostly stalled
        endcase
      end
    end
  end

  // ---- sender ----
  // holds the request until the block takes it
  task automatic send_request(logic [2:0] mode, logic [31:0] value, logic [3:0] pos);
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {4'b0, pos, value};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic idle_for(int unsigned cycles);
    s_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // waits until every result owed so far has come back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.due_count() != 0) @(posedge clk);
  endtask

  function automatic logic [2:0] pick_mode(bit fill_bias);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < (fill_bias ? 40 : 15)) return bls_pkg::MODE_PUSH;
    if (roll < 55) return bls_pkg::MODE_POP;
    if (roll < 67) return bls_pkg::MODE_SEARCH;
    if (roll < 75) return bls_pkg::MODE_DISPLAY;
    if (roll < 87) return bls_pkg::MODE_UPDATE;
    if (roll < 95) return bls_pkg::MODE_PEEK;
    return roll[0] ? MODE_SPARE_A : MODE_SPARE_B;
  endfunction

  // mostly a small pool of words so that searches find repeats
  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 99) >= 70) return $urandom;
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'h8000_0000;
      default: return 32'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic logic [3:0] pick_position();
    if ($urandom_range(0, 3) == 0) return 4'($urandom_range(8, 15));
    return 4'($urandom_range(0, 7));
  endfunction

  initial begin : stimulus
    int unsigned counted;
    int unsigned burst_left;
    int unsigned no_gap_left;
    bit          fill_bias;
    logic [2:0]  mode;
    counted     = 0;
    burst_left  = 0;
    no_gap_left = 0;
    fill_bias   = 1'b1;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // -- directed: empty stack, extremes, full stack, bounds --
    send_request(bls_pkg::MODE_PEEK,    32'h0,         4'd0);   // peek on empty
    send_request(bls_pkg::MODE_POP,     32'h0,         4'd0);   // pop on empty
    send_request(bls_pkg::MODE_DISPLAY, 32'h0,         4'd0);   // display on empty
    send_request(bls_pkg::MODE_SEARCH,  32'h0,         4'd0);   // search on empty
    send_request(bls_pkg::MODE_UPDATE,  32'hFFFF_FFFF, 4'd15);  // position past the end
    send_request(bls_pkg::MODE_UPDATE,  32'h5A5A_A5A5, 4'd3);   // above the fill count
    send_request(bls_pkg::MODE_PUSH,    32'h8000_0000, 4'd0);
    send_request(bls_pkg::MODE_PUSH,    32'h7FFF_FFFF, 4'd15);
    send_request(bls_pkg::MODE_PUSH,    32'h0000_0000, 4'd0);
    send_request(bls_pkg::MODE_PUSH,    32'hFFFF_FFFF, 4'd0);
    send_request(bls_pkg::MODE_PUSH,    32'h7FFF_FFFF, 4'd0);
    send_request(bls_pkg::MODE_PUSH,    32'h0000_0001, 4'd0);
    send_request(bls_pkg::MODE_PUSH,    32'h7FFF_FFFF, 4'd0);
    send_request(bls_pkg::MODE_PUSH,    32'h8000_0000, 4'd0);   // now full
    send_request(bls_pkg::MODE_PUSH,    32'h0000_0005, 4'd0);   // push on full
    send_request(bls_pkg::MODE_SEARCH,  32'h7FFF_FFFF, 4'd0);   // several matches
    send_request(bls_pkg::MODE_SEARCH,  32'h0000_3039, 4'd0);   // no match
    send_request(bls_pkg::MODE_DISPLAY, 32'h0,         4'd0);   // all eight slots
    send_request(bls_pkg::MODE_UPDATE,  32'h0000_002A, 4'd7);   // top slot
    send_request(bls_pkg::MODE_UPDATE,  32'h0000_0063, 4'd8);   // first bad position
    send_request(bls_pkg::MODE_PEEK,    32'h0,         4'd0);
    send_request(MODE_SPARE_A,          32'hFFFF_FFFF, 4'd15);  // dropped
    send_request(MODE_SPARE_B,          32'h0,         4'd0);   // dropped
    send_request(bls_pkg::MODE_POP,     32'h0,         4'd0);
    send_request(bls_pkg::MODE_UPDATE,  32'hFFFF_FFFE, 4'd0);   // bottom slot

    // -- random: alternate phases that fill and drain the stack --
    while (counted < RANDOM_REQUESTS) begin
      if (counted % 40 == 0) fill_bias = $urandom_range(0, 1);

      // receiver goes quiet while requests keep coming, so the block backs up
      if (counted == 100) begin
        hold_flip   <= ~hold_flip;
        no_gap_left = 60;
      end
      // one pause with nothing outstanding
      if (counted == 250) wait_drained();

      if (burst_left == 0) begin
        if (no_gap_left == 0) idle_for($urandom_range(1, 6));
        burst_left = $urandom_range(1, 40);
      end

      mode = pick_mode(fill_bias);
      send_request(mode, pick_value(), pick_position());
      if (mode != MODE_SPARE_A && mode != MODE_SPARE_B) counted++;
      burst_left--;
      if (no_gap_left > 0) no_gap_left--;
    end

    // -- wind down: all results in, then a short settle --
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.due_count() == 0) begin
      $display("PASS bounded_lifo_stack_engine");
    end else begin
      $display("FAIL bounded_lifo_stack_engine");
    end
    $finish;
  end

endmodule
